### src/dad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_pkg
// Shared widths, register indexes, stage numbering and types for the
// detector anchor decoder.
// ----------------------------------------------------------------------------
package dad_pkg;

   // field widths
   localparam int ANCHOR_W   = 14;
   localparam int COORD_W    = 20;
   localparam int DBL_W      = COORD_W + 2;        // 2*c +/- s
   localparam int SCORE_W    = 16;
   localparam int CLS_W      = 3;
   localparam int THR_W      = 16;
   localparam int MSIZE_W    = 13;
   localparam int SIZE_W     = 14;
   localparam int CORNER_W   = 17;

   localparam int MAX_CLASSES     = 7;
   localparam int COORD_FRAC_BITS = 4;

   // divider: divisor is 2*model_size, quotient saturates at CORNER_W bits
   localparam int DIVR_W     = MSIZE_W + 1;
   localparam int DIV_BITS   = CORNER_W;
   localparam int REM_W      = DIVR_W + DIV_BITS;
   localparam int PROD_W     = DBL_W + SIZE_W + 1;
   localparam int HI_W       = SIZE_W + 8;
   localparam int CORNER_MAX = (1 << CORNER_W) - 1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MODEL_SIZE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLASSES_USED = 3'd4;

   localparam logic [THR_W-1:0]   RST_THRESHOLD    = 16'd16384;
   localparam logic [MSIZE_W-1:0] RST_MODEL_SIZE   = 13'd640;
   localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = 14'd640;
   localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = 14'd640;
   localparam logic [CLS_W-1:0]   RST_CLASSES_USED = 3'd4;

   // pipeline stage numbering
   localparam int ST_IN      = 0;                   // capture, doubled corners, pair argmax
   localparam int ST_MUL     = 1;                   // multiply by frame size, quad argmax
   localparam int ST_PRE     = 2;                   // threshold, sign, saturation check
   localparam int ST_DIV0    = 3;                   // first quotient bit
   localparam int ST_OUT     = ST_DIV0 + DIV_BITS;  // clamp
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic [SIZE_W-1:0]   size;
      logic [DIVR_W-1:0]   divisor;
      logic [CORNER_W-1:0] upper;
      logic                size_zero;
   } corner_cfg_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [CLS_W-1:0]   cls;
      logic               ok;
   } cand_type;

   typedef struct packed {
      logic [ANCHOR_W-1:0] anchor;
      logic [CLS_W-1:0]    cls;
      logic [SCORE_W-1:0]  conf;
   } side_type;

   typedef struct packed {
      side_type            side;
      logic [CORNER_W-1:0] left;
      logic [CORNER_W-1:0] top;
      logic [CORNER_W-1:0] right;
      logic [CORNER_W-1:0] bottom;
   } res_type;

endpackage

### src/dad_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_corner
// One corner lane: doubled corner times frame size, then a one bit per
// stage restoring divide by 2*model_size, saturated and clamped to the frame.
// ----------------------------------------------------------------------------
module dad_corner (
   input  logic                                  clock,
   input  logic                                  adv,
   input  dad_pkg::corner_cfg_type               cfg,
   input  logic signed [dad_pkg::DBL_W-1:0]      dbl,
   output logic [dad_pkg::CORNER_W-1:0]          corner
);

   localparam int SAT_W = dad_pkg::PROD_W - 1 - dad_pkg::DIV_BITS;

   logic signed [dad_pkg::PROD_W-1:0]   prod_ff;
   logic                                zero_ff [dad_pkg::ST_PRE:dad_pkg::ST_OUT-1];
   logic                                sat_ff  [dad_pkg::ST_PRE:dad_pkg::ST_OUT-1];
   logic [dad_pkg::REM_W-1:0]           rem_ff  [dad_pkg::ST_PRE:dad_pkg::ST_OUT-2];
   logic [dad_pkg::DIV_BITS-1:0]        q_ff    [dad_pkg::ST_DIV0:dad_pkg::ST_OUT-1];
   logic [dad_pkg::CORNER_W-1:0]        corner_ff;
   logic [dad_pkg::CORNER_W-1:0]        corner_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= dbl * $signed({1'b0, cfg.size});
      end
   end

   // negative products truncate to zero or below, so the corner is 0
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[dad_pkg::ST_PRE] <= prod_ff[dad_pkg::PROD_W-1] | cfg.size_zero;
         sat_ff[dad_pkg::ST_PRE]  <= prod_ff[dad_pkg::PROD_W-2:dad_pkg::DIV_BITS] >=
                                     SAT_W'(cfg.divisor);
         rem_ff[dad_pkg::ST_PRE]  <= prod_ff[dad_pkg::REM_W-1:0];
      end
   end

   for (genvar s = dad_pkg::ST_DIV0; s < dad_pkg::ST_OUT; s++) begin : g_div
      localparam int BIT = dad_pkg::ST_OUT - 1 - s;
      logic [dad_pkg::REM_W-1:0]    trial;
      logic                         take;
      logic [dad_pkg::DIV_BITS-1:0] q_prev;

      assign trial = dad_pkg::REM_W'(cfg.divisor) << BIT;
      assign take  = rem_ff[s-1] >= trial;

      if (s == dad_pkg::ST_DIV0) begin : g_first
         assign q_prev = '0;
      end else begin : g_next
         assign q_prev = q_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff[s]  <= zero_ff[s-1];
            sat_ff[s]   <= sat_ff[s-1];
            q_ff[s]     <= q_prev | (dad_pkg::DIV_BITS'(take) << BIT);
         end
      end

      if (s < dad_pkg::ST_OUT - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s] <= take ? rem_ff[s-1] - trial : rem_ff[s-1];
            end
         end
      end
   end

   always_comb begin
      if (zero_ff[dad_pkg::ST_OUT-1]) begin
         corner_in = '0;
      end else if (sat_ff[dad_pkg::ST_OUT-1] || (q_ff[dad_pkg::ST_OUT-1] > cfg.upper)) begin
         corner_in = cfg.upper;
      end else begin
         corner_in = q_ff[dad_pkg::ST_OUT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         corner_ff <= corner_in;
      end
   end

   assign corner = corner_ff;

endmodule

### src/detector_anchor_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_anchor_decode
// Per-anchor argmax, score threshold and box-to-corner conversion scaled to
// the original frame, with a pipelined divider in each corner lane.
// ----------------------------------------------------------------------------
// Pipeline: 21 stages, 17 of them one quotient bit each, plus the output
//   register. Throughput: one item per cycle while the skid entry is free
//   and req_stall is low.
// A two-entry output buffer keeps items flowing while one result waits.
// Reset: synchronous; pipeline and output buffer empty, registers at defaults.
module detector_anchor_decode (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dad_pkg::ANCHOR_W-1:0]         req_anchor_index,
   input  logic signed [dad_pkg::COORD_W-1:0]   req_center_x,
   input  logic signed [dad_pkg::COORD_W-1:0]   req_center_y,
   input  logic signed [dad_pkg::COORD_W-1:0]   req_box_width,
   input  logic signed [dad_pkg::COORD_W-1:0]   req_box_height,
   input  logic [dad_pkg::SCORE_W-1:0]          req_score_0,
   input  logic [dad_pkg::SCORE_W-1:0]          req_score_1,
   input  logic [dad_pkg::SCORE_W-1:0]          req_score_2,
   input  logic [dad_pkg::SCORE_W-1:0]          req_score_3,
   input  logic [dad_pkg::SCORE_W-1:0]          req_score_4,
   input  logic [dad_pkg::SCORE_W-1:0]          req_score_5,
   input  logic [dad_pkg::SCORE_W-1:0]          req_score_6,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dad_pkg::ANCHOR_W-1:0]         rsp_detected_anchor,
   output logic [dad_pkg::CLS_W-1:0]            rsp_class,
   output logic [dad_pkg::SCORE_W-1:0]          rsp_confidence,
   output logic [dad_pkg::CORNER_W-1:0]         rsp_left,
   output logic [dad_pkg::CORNER_W-1:0]         rsp_top,
   output logic [dad_pkg::CORNER_W-1:0]         rsp_right,
   output logic [dad_pkg::CORNER_W-1:0]         rsp_bottom,

   input  logic                                 csr_write,
   input  logic [dad_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dad_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [dad_pkg::THR_W-1:0]   thr_ff;
   logic [dad_pkg::MSIZE_W-1:0] msize_ff;
   logic [dad_pkg::SIZE_W-1:0]  fwidth_ff;
   logic [dad_pkg::SIZE_W-1:0]  fheight_ff;
   logic [dad_pkg::CLS_W-1:0]   ncls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= dad_pkg::RST_THRESHOLD;
         msize_ff   <= dad_pkg::RST_MODEL_SIZE;
         fwidth_ff  <= dad_pkg::RST_FRAME_WIDTH;
         fheight_ff <= dad_pkg::RST_FRAME_HEIGHT;
         ncls_ff    <= dad_pkg::RST_CLASSES_USED;
      end else if (csr_write) begin
         unique case (csr_index)
            dad_pkg::REG_THRESHOLD:    thr_ff     <= csr_wdata[dad_pkg::THR_W-1:0];
            dad_pkg::REG_MODEL_SIZE:   msize_ff   <= csr_wdata[dad_pkg::MSIZE_W-1:0];
            dad_pkg::REG_FRAME_WIDTH:  fwidth_ff  <= csr_wdata[dad_pkg::SIZE_W-1:0];
            dad_pkg::REG_FRAME_HEIGHT: fheight_ff <= csr_wdata[dad_pkg::SIZE_W-1:0];
            dad_pkg::REG_CLASSES_USED: ncls_ff    <= csr_wdata[dad_pkg::CLS_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic dad_pkg::corner_cfg_type make_cfg(
      input logic [dad_pkg::SIZE_W-1:0]  size,
      input logic [dad_pkg::MSIZE_W-1:0] msize
   );
      dad_pkg::corner_cfg_type      r;
      logic [dad_pkg::HI_W-1:0]     hi;
      hi = dad_pkg::HI_W'(size - 1'b1) << dad_pkg::COORD_FRAC_BITS;
      r.size      = size;
      r.size_zero = (size == '0);
      // model size 0 counts as 1
      r.divisor   = (msize == '0) ? dad_pkg::DIVR_W'(2) : {msize, 1'b0};
      if (r.size_zero) begin
         r.upper = '0;
      end else if (hi > dad_pkg::HI_W'(dad_pkg::CORNER_MAX)) begin
         r.upper = dad_pkg::CORNER_W'(dad_pkg::CORNER_MAX);
      end else begin
         r.upper = hi[dad_pkg::CORNER_W-1:0];
      end
      return r;
   endfunction

   dad_pkg::corner_cfg_type cfg_x;
   dad_pkg::corner_cfg_type cfg_y;

   assign cfg_x = make_cfg(fwidth_ff, msize_ff);
   assign cfg_y = make_cfg(fheight_ff, msize_ff);

   // ------------------------------------------------------------------
   // pipeline control: all stages advance together unless the skid is full
   // ------------------------------------------------------------------
   logic [dad_pkg::NUM_STAGES-1:0] vld_ff;
   logic [dad_pkg::NUM_STAGES-1:0] vld_in;
   logic                           adv;
   logic                           skid_vld_ff;
   logic                           keep;

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_comb begin
      vld_in = {vld_ff[dad_pkg::NUM_STAGES-2:0], req_valid};
      vld_in[dad_pkg::ST_PRE] = vld_ff[dad_pkg::ST_MUL] & keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------------------
   // argmax: pairs at capture, quads next, final pick with the threshold
   // ------------------------------------------------------------------
   function automatic dad_pkg::cand_type pick(
      input dad_pkg::cand_type a,
      input dad_pkg::cand_type b
   );
      dad_pkg::cand_type r;
      // a always holds the lower class index, so ties keep a
      if (b.ok && (!a.ok || (b.score > a.score))) begin
         r = b;
      end else begin
         r = a;
      end
      r.ok = a.ok | b.ok;
      return r;
   endfunction

   logic [dad_pkg::CLS_W-1:0]   ncls;
   logic [dad_pkg::SCORE_W-1:0] score_in [dad_pkg::MAX_CLASSES];
   dad_pkg::cand_type           cand_in  [dad_pkg::MAX_CLASSES];
   dad_pkg::cand_type           pair_in  [4];
   dad_pkg::cand_type           pair_ff  [4];
   dad_pkg::cand_type           quad_ff  [2];
   dad_pkg::cand_type           best;

   always_comb begin
      if (ncls_ff == '0) begin
         ncls = dad_pkg::CLS_W'(1);
      end else if (ncls_ff > dad_pkg::CLS_W'(dad_pkg::MAX_CLASSES)) begin
         ncls = dad_pkg::CLS_W'(dad_pkg::MAX_CLASSES);
      end else begin
         ncls = ncls_ff;
      end
   end

   assign score_in[0] = req_score_0;
   assign score_in[1] = req_score_1;
   assign score_in[2] = req_score_2;
   assign score_in[3] = req_score_3;
   assign score_in[4] = req_score_4;
   assign score_in[5] = req_score_5;
   assign score_in[6] = req_score_6;

   always_comb begin
      for (int c = 0; c < dad_pkg::MAX_CLASSES; c++) begin
         cand_in[c].score = score_in[c];
         cand_in[c].cls   = dad_pkg::CLS_W'(c);
         cand_in[c].ok    = dad_pkg::CLS_W'(c) < ncls;
      end
      pair_in[0] = pick(cand_in[0], cand_in[1]);
      pair_in[1] = pick(cand_in[2], cand_in[3]);
      pair_in[2] = pick(cand_in[4], cand_in[5]);
      pair_in[3] = cand_in[6];
   end

   assign best = pick(quad_ff[0], quad_ff[1]);
   assign keep = best.score >= thr_ff;

   // ------------------------------------------------------------------
   // doubled corners in Q.(F+1)
   // ------------------------------------------------------------------
   logic signed [dad_pkg::DBL_W-1:0] dbl_in [4];
   logic signed [dad_pkg::DBL_W-1:0] dbl_ff [4];
   logic [dad_pkg::ANCHOR_W-1:0]     anchor_ff [dad_pkg::ST_IN:dad_pkg::ST_MUL];
   dad_pkg::side_type                side_ff   [dad_pkg::ST_PRE:dad_pkg::ST_OUT];

   always_comb begin
      dbl_in[0] = {req_center_x[dad_pkg::COORD_W-1], req_center_x, 1'b0}
                - {{2{req_box_width[dad_pkg::COORD_W-1]}}, req_box_width};
      dbl_in[1] = {req_center_y[dad_pkg::COORD_W-1], req_center_y, 1'b0}
                - {{2{req_box_height[dad_pkg::COORD_W-1]}}, req_box_height};
      dbl_in[2] = {req_center_x[dad_pkg::COORD_W-1], req_center_x, 1'b0}
                + {{2{req_box_width[dad_pkg::COORD_W-1]}}, req_box_width};
      dbl_in[3] = {req_center_y[dad_pkg::COORD_W-1], req_center_y, 1'b0}
                + {{2{req_box_height[dad_pkg::COORD_W-1]}}, req_box_height};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         anchor_ff[dad_pkg::ST_IN]  <= req_anchor_index;
         dbl_ff                     <= dbl_in;
         pair_ff                    <= pair_in;
         anchor_ff[dad_pkg::ST_MUL] <= anchor_ff[dad_pkg::ST_IN];
         quad_ff[0]                 <= pick(pair_ff[0], pair_ff[1]);
         quad_ff[1]                 <= pick(pair_ff[2], pair_ff[3]);
         side_ff[dad_pkg::ST_PRE].anchor <= anchor_ff[dad_pkg::ST_MUL];
         side_ff[dad_pkg::ST_PRE].cls    <= best.cls;
         side_ff[dad_pkg::ST_PRE].conf   <= best.score;
      end
   end

   for (genvar s = dad_pkg::ST_PRE + 1; s <= dad_pkg::ST_OUT; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // corner lanes: left, top, right, bottom
   // ------------------------------------------------------------------
   logic [dad_pkg::CORNER_W-1:0] corner [4];

   dad_corner u_left (
      .clock  (clock),
      .adv    (adv),
      .cfg    (cfg_x),
      .dbl    (dbl_ff[0]),
      .corner (corner[0])
   );

   dad_corner u_top (
      .clock  (clock),
      .adv    (adv),
      .cfg    (cfg_y),
      .dbl    (dbl_ff[1]),
      .corner (corner[1])
   );

   dad_corner u_right (
      .clock  (clock),
      .adv    (adv),
      .cfg    (cfg_x),
      .dbl    (dbl_ff[2]),
      .corner (corner[2])
   );

   dad_corner u_bottom (
      .clock  (clock),
      .adv    (adv),
      .cfg    (cfg_y),
      .dbl    (dbl_ff[3]),
      .corner (corner[3])
   );

   // ------------------------------------------------------------------
   // output register with one skid entry
   // ------------------------------------------------------------------
   dad_pkg::res_type res_in;
   dad_pkg::res_type out_ff;
   dad_pkg::res_type skid_ff;
   logic             out_vld_ff;
   logic             incoming;
   logic             taken;

   assign res_in.side   = side_ff[dad_pkg::ST_OUT];
   assign res_in.left   = corner[0];
   assign res_in.top    = corner[1];
   assign res_in.right  = corner[2];
   assign res_in.bottom = corner[3];

   assign incoming = adv & vld_ff[dad_pkg::ST_OUT];
   assign taken    = out_vld_ff & !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (taken) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (incoming) begin
         if (out_vld_ff && !taken) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (taken) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (taken) begin
            out_ff <= skid_ff;
         end
      end else if (incoming) begin
         if (out_vld_ff && !taken) begin
            skid_ff <= res_in;
         end else begin
            out_ff <= res_in;
         end
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_detected_anchor = out_ff.side.anchor;
   assign rsp_class           = out_ff.side.cls;
   assign rsp_confidence      = out_ff.side.conf;
   assign rsp_left            = out_ff.left;
   assign rsp_top             = out_ff.top;
   assign rsp_right           = out_ff.right;
   assign rsp_bottom          = out_ff.bottom;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output buffer not empty after reset");

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held without a pending result");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_stall && !skid_vld_ff && vld_ff[dad_pkg::ST_OUT]) |=> skid_vld_ff)
      else $error("result leaving the pipeline was not parked in the skid entry");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[dad_pkg::ST_IN])
      else $error("accepted item did not enter the pipeline");

endmodule

### verif/detector_anchor_decode_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_anchor_decode_test
// Self-checking bench for the anchor decoder. A queue of anchors feeds a
// clocked driver. Every accepted anchor is decoded in the bench: argmax,
// threshold, scaled and clamped corners. The expected detections are
// compared field by field with what the block gives. It runs through
// default, extreme, degenerate and random register settings, with random
// idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module detector_anchor_decode_test;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 40;     // covers the pipeline and output buffer, plus margin
   localparam int HOLD_CYCLES   = 150;

   typedef struct packed {
      logic [dad_pkg::ANCHOR_W-1:0]                         anchor;
      logic signed [dad_pkg::COORD_W-1:0]                   center_x;
      logic signed [dad_pkg::COORD_W-1:0]                   center_y;
      logic signed [dad_pkg::COORD_W-1:0]                   box_width;
      logic signed [dad_pkg::COORD_W-1:0]                   box_height;
      logic [dad_pkg::MAX_CLASSES-1:0][dad_pkg::SCORE_W-1:0] score;
   } anchor_type;

   typedef struct packed {
      logic [dad_pkg::ANCHOR_W-1:0] anchor;
      logic [dad_pkg::CLS_W-1:0]    cls;
      logic [dad_pkg::SCORE_W-1:0]  confidence;
      logic [dad_pkg::CORNER_W-1:0] left;
      logic [dad_pkg::CORNER_W-1:0] top;
      logic [dad_pkg::CORNER_W-1:0] right;
      logic [dad_pkg::CORNER_W-1:0] bottom;
   } detection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid        = 1'b0;
   logic                               req_stall;
   logic [dad_pkg::ANCHOR_W-1:0]       req_anchor_index = '0;
   logic signed [dad_pkg::COORD_W-1:0] req_center_x     = '0;
   logic signed [dad_pkg::COORD_W-1:0] req_center_y     = '0;
   logic signed [dad_pkg::COORD_W-1:0] req_box_width    = '0;
   logic signed [dad_pkg::COORD_W-1:0] req_box_height   = '0;
   logic [dad_pkg::SCORE_W-1:0]        req_score_0      = '0;
   logic [dad_pkg::SCORE_W-1:0]        req_score_1      = '0;
   logic [dad_pkg::SCORE_W-1:0]        req_score_2      = '0;
   logic [dad_pkg::SCORE_W-1:0]        req_score_3      = '0;
   logic [dad_pkg::SCORE_W-1:0]        req_score_4      = '0;
   logic [dad_pkg::SCORE_W-1:0]        req_score_5      = '0;
   logic [dad_pkg::SCORE_W-1:0]        req_score_6      = '0;

   logic                               rsp_valid;
   logic                               rsp_stall        = 1'b0;
   logic [dad_pkg::ANCHOR_W-1:0]       rsp_detected_anchor;
   logic [dad_pkg::CLS_W-1:0]          rsp_class;
   logic [dad_pkg::SCORE_W-1:0]        rsp_confidence;
   logic [dad_pkg::CORNER_W-1:0]       rsp_left;
   logic [dad_pkg::CORNER_W-1:0]       rsp_top;
   logic [dad_pkg::CORNER_W-1:0]       rsp_right;
   logic [dad_pkg::CORNER_W-1:0]       rsp_bottom;

   logic                               csr_write        = 1'b0;
   logic [dad_pkg::CSR_IDX_W-1:0]      csr_index        = '0;
   logic [dad_pkg::CSR_DATA_W-1:0]     csr_wdata        = '0;

   // bench copy of the registers
   logic [dad_pkg::THR_W-1:0]   cfg_threshold    = dad_pkg::RST_THRESHOLD;
   logic [dad_pkg::MSIZE_W-1:0] cfg_model_size   = dad_pkg::RST_MODEL_SIZE;
   logic [dad_pkg::SIZE_W-1:0]  cfg_frame_width  = dad_pkg::RST_FRAME_WIDTH;
   logic [dad_pkg::SIZE_W-1:0]  cfg_frame_height = dad_pkg::RST_FRAME_HEIGHT;
   logic [dad_pkg::CLS_W-1:0]   cfg_classes      = dad_pkg::RST_CLASSES_USED;

   anchor_type    pending_anchors[$];
   detection_type expected_detections[$];
   anchor_type    in_flight;
   detection_type predicted;
   detection_type got;

   int queued_count       = 0;
   int accepted_count     = 0;
   int detections_checked = 0;
   int settings_count     = 0;
   int errors             = 0;
   int cycle_count        = 0;
   int sender_idle_pct    = 17;
   int receiver_idle_pct  = 17;
   int hold_request       = 0;
   int holds_served       = 0;
   int hold_left          = 0;

   detector_anchor_decode dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_anchor_index    (req_anchor_index),
      .req_center_x        (req_center_x),
      .req_center_y        (req_center_y),
      .req_box_width       (req_box_width),
      .req_box_height      (req_box_height),
      .req_score_0         (req_score_0),
      .req_score_1         (req_score_1),
      .req_score_2         (req_score_2),
      .req_score_3         (req_score_3),
      .req_score_4         (req_score_4),
      .req_score_5         (req_score_5),
      .req_score_6         (req_score_6),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_detected_anchor (rsp_detected_anchor),
      .rsp_class           (rsp_class),
      .rsp_confidence      (rsp_confidence),
      .rsp_left            (rsp_left),
      .rsp_top             (rsp_top),
      .rsp_right           (rsp_right),
      .rsp_bottom          (rsp_bottom),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // doubled corner (Q.5) times frame size over 2*model size, then clamp
   function automatic logic [dad_pkg::CORNER_W-1:0] scale_corner(input longint doubled,
                                                                 input longint size,
                                                                 input longint msize);
      longint scaled;
      longint upper;
      scaled = (doubled * size) / (msize * 2);
      upper  = (size - 1) * (longint'(1) << dad_pkg::COORD_FRAC_BITS);
      if (upper > longint'(dad_pkg::CORNER_MAX)) upper = longint'(dad_pkg::CORNER_MAX);
      if (scaled > upper) scaled = upper;
      // zero frame size leaves a negative upper bound; zero wins
      if (scaled < 0) scaled = 0;
      return scaled[dad_pkg::CORNER_W-1:0];
   endfunction

   function automatic bit decode_anchor(input anchor_type a, output detection_type d);
      int                          n;
      int                          win_cls;
      logic [dad_pkg::SCORE_W-1:0] best;
      longint                      msz;
      longint                      cx;
      longint                      cy;
      longint                      bw;
      longint                      bh;
      d = '0;
      n = int'(cfg_classes);
      if (n < 1) n = 1;
      if (n > dad_pkg::MAX_CLASSES) n = dad_pkg::MAX_CLASSES;
      best    = a.score[0];
      win_cls = 0;
      for (int c = 1; c < n; c++) begin
         if (a.score[c] > best) begin
            best    = a.score[c];
            win_cls = c;
         end
      end
      if (best < cfg_threshold) return 1'b0;
      msz = (cfg_model_size == '0) ? longint'(1) : longint'(cfg_model_size);
      cx  = longint'($signed(a.center_x));
      cy  = longint'($signed(a.center_y));
      bw  = longint'($signed(a.box_width));
      bh  = longint'($signed(a.box_height));
      d.anchor     = a.anchor;
      d.cls        = win_cls[dad_pkg::CLS_W-1:0];
      d.confidence = best;
      d.left       = scale_corner(2 * cx - bw, longint'(cfg_frame_width), msz);
      d.top        = scale_corner(2 * cy - bh, longint'(cfg_frame_height), msz);
      d.right      = scale_corner(2 * cx + bw, longint'(cfg_frame_width), msz);
      d.bottom     = scale_corner(2 * cy + bh, longint'(cfg_frame_height), msz);
      return 1'b1;
   endfunction

   function automatic anchor_type make_anchor(input int idx, input int cx, input int cy,
                                              input int w, input int h,
                                              input int s0, input int s1, input int s2,
                                              input int s3, input int s4, input int s5,
                                              input int s6);
      anchor_type a;
      a.anchor     = dad_pkg::ANCHOR_W'(idx);
      a.center_x   = dad_pkg::COORD_W'(cx);
      a.center_y   = dad_pkg::COORD_W'(cy);
      a.box_width  = dad_pkg::COORD_W'(w);
      a.box_height = dad_pkg::COORD_W'(h);
      a.score[0]   = dad_pkg::SCORE_W'(s0);
      a.score[1]   = dad_pkg::SCORE_W'(s1);
      a.score[2]   = dad_pkg::SCORE_W'(s2);
      a.score[3]   = dad_pkg::SCORE_W'(s3);
      a.score[4]   = dad_pkg::SCORE_W'(s4);
      a.score[5]   = dad_pkg::SCORE_W'(s5);
      a.score[6]   = dad_pkg::SCORE_W'(s6);
      return a;
   endfunction

   // mostly boxes inside the model frame, some raw 20-bit values
   function automatic anchor_type rand_anchor();
      anchor_type a;
      int         span;
      int         j;
      int         k;
      span = ((cfg_model_size == '0) ? 1 : int'(cfg_model_size)) * 16;
      a.anchor = dad_pkg::ANCHOR_W'($urandom);
      if ($urandom_range(9) < 2) begin
         a.center_x   = dad_pkg::COORD_W'($urandom);
         a.center_y   = dad_pkg::COORD_W'($urandom);
         a.box_width  = dad_pkg::COORD_W'($urandom);
         a.box_height = dad_pkg::COORD_W'($urandom);
      end else begin
         a.center_x   = dad_pkg::COORD_W'(int'($urandom_range(span + span / 4)) - span / 8);
         a.center_y   = dad_pkg::COORD_W'(int'($urandom_range(span + span / 4)) - span / 8);
         a.box_width  = dad_pkg::COORD_W'($urandom_range(span / 2));
         a.box_height = dad_pkg::COORD_W'($urandom_range(span / 2));
         if ($urandom_range(15) == 0) a.box_width = -a.box_width;
         if ($urandom_range(15) == 0) a.box_height = -a.box_height;
      end
      for (int c = 0; c < dad_pkg::MAX_CLASSES; c++) a.score[c] = dad_pkg::SCORE_W'($urandom);
      if ($urandom_range(3) == 0) begin
         j = int'($urandom_range(dad_pkg::MAX_CLASSES - 1));
         k = int'($urandom_range(dad_pkg::MAX_CLASSES - 1));
         a.score[j] = a.score[k];
      end
      if ($urandom_range(7) == 0) begin
         for (int c = 0; c < dad_pkg::MAX_CLASSES; c++)
            a.score[c] = dad_pkg::SCORE_W'($urandom_range(int'(cfg_threshold)));
      end
      return a;
   endfunction

   task automatic offer(input anchor_type a);
      pending_anchors = {pending_anchors, a};
      queued_count++;
   endtask

   task automatic offer_random(input int count);
      for (int i = 0; i < count; i++) offer(rand_anchor());
   endtask

   task automatic write_reg(input logic [dad_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[dad_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         dad_pkg::REG_THRESHOLD:    cfg_threshold    = value[dad_pkg::THR_W-1:0];
         dad_pkg::REG_MODEL_SIZE:   cfg_model_size   = value[dad_pkg::MSIZE_W-1:0];
         dad_pkg::REG_FRAME_WIDTH:  cfg_frame_width  = value[dad_pkg::SIZE_W-1:0];
         dad_pkg::REG_FRAME_HEIGHT: cfg_frame_height = value[dad_pkg::SIZE_W-1:0];
         dad_pkg::REG_CLASSES_USED: cfg_classes      = value[dad_pkg::CLS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input int thr, input int msz, input int fw, input int fh,
                               input int ncls);
      write_reg(dad_pkg::REG_THRESHOLD, thr);
      write_reg(dad_pkg::REG_MODEL_SIZE, msz);
      write_reg(dad_pkg::REG_FRAME_WIDTH, fw);
      write_reg(dad_pkg::REG_FRAME_HEIGHT, fh);
      write_reg(dad_pkg::REG_CLASSES_USED, ncls);
      settings_count++;
      @(negedge clock);
   endtask

   // wait until every queued anchor went in and every detection came out
   task automatic drain();
      while (accepted_count != queued_count || expected_detections.size() != 0)
         @(negedge clock);
   endtask

   // anchors below threshold may still be in the pipe after the last detection
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
         errors++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_count++;
            if (decode_anchor(in_flight, predicted))
               expected_detections = {expected_detections, predicted};
         end
         if (!req_valid || !req_stall) begin
            if (pending_anchors.size() != 0 &&
                !(sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)) begin
               in_flight = pending_anchors.pop_front();
               req_valid        <= 1'b1;
               req_anchor_index <= in_flight.anchor;
               req_center_x     <= in_flight.center_x;
               req_center_y     <= in_flight.center_y;
               req_box_width    <= in_flight.box_width;
               req_box_height   <= in_flight.box_height;
               req_score_0      <= in_flight.score[0];
               req_score_1      <= in_flight.score[1];
               req_score_2      <= in_flight.score[2];
               req_score_3      <= in_flight.score[3];
               req_score_4      <= in_flight.score[4];
               req_score_5      <= in_flight.score[5];
               req_score_6      <= in_flight.score[6];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_detections.size() == 0) begin
               $display("%0t: unexpected detection, expected none, actual anchor %0d",
                        $time, rsp_detected_anchor);
               errors++;
            end else begin
               got = expected_detections.pop_front();
               detections_checked++;
               check_field("detected_anchor", int'(got.anchor), int'(rsp_detected_anchor));
               check_field("class", int'(got.cls), int'(rsp_class));
               check_field("confidence", int'(got.confidence), int'(rsp_confidence));
               check_field("left", int'(got.left), int'(rsp_left));
               check_field("top", int'(got.top), int'(rsp_top));
               check_field("right", int'(got.right), int'(rsp_right));
               check_field("bottom", int'(got.bottom), int'(rsp_bottom));
            end
         end
         if (holds_served != hold_request) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d of %0d anchors accepted, %0d detections outstanding",
                  $time, accepted_count, queued_count, expected_detections.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      anchor_type a;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: threshold 0.25, 640 model, 640x640 frame, four classes
      offer(make_anchor(0, 5120, 5120, 1600, 3200, 30000, 0, 0, 0, 0, 0, 0));
      offer(make_anchor(16383, 5120, 5120, 1600, 1600, 0, 0, 0, 0, 0, 0, 0));
      offer(make_anchor(1, 4000, 6000, 800, 800, 100, 16384, 200, 300, 0, 0, 0));
      offer(make_anchor(2, 4000, 6000, 800, 800, 100, 200, 16383, 300, 0, 0, 0));
      offer(make_anchor(3, 2000, 2000, 640, 480, 40000, 100, 40000, 5, 0, 0, 0));
      offer(make_anchor(4, 2000, 2000, 640, 480, 9, 50000, 8, 50000, 65535, 65535, 65535));
      offer(make_anchor(5, 8000, 3000, 320, 160, 1, 2, 3, 65535, 0, 0, 0));
      offer(make_anchor(6, 524287, 524287, 524287, 524287, 65535, 0, 0, 0, 0, 0, 0));
      offer(make_anchor(7, -524288, -524288, -524288, -524288, 65535, 0, 0, 0, 0, 0, 0));
      offer(make_anchor(8, -524288, 524287, 524287, -524288, 65535, 0, 0, 0, 0, 0, 0));
      // negative box size: left ends up right of right
      offer(make_anchor(9, 5120, 5120, -1600, -800, 0, 20000, 0, 0, 0, 0, 0));
      offer(make_anchor(10, 100, 50, 3200, 3200, 20000, 0, 0, 0, 0, 0, 0));
      offer(make_anchor(11, 10000, 10000, 2000, 2000, 20000, 0, 0, 0, 0, 0, 0));
      offer(make_anchor(12, 1, 1, 0, 0, 20000, 0, 0, 0, 0, 0, 0));
      offer(make_anchor(13, 7, -7, 3, 5, 65535, 0, 0, 0, 0, 0, 0));
      offer(make_anchor('h2AAA, 'hAAAAA, 'h55555, 'h55555, 'hAAAAA,
                        'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA));
      offer(make_anchor('h1555, 'h55555, 'hAAAAA, 'hAAAAA, 'h55555,
                        'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555));
      offer_random(80);
      drain();

      // receiver holds off long enough for the block to fill and stall its input
      sender_idle_pct = 0;
      offer_random(60);
      hold_request++;
      settle();
      sender_idle_pct = 17;

      // extremes: no threshold, smallest model, 1-pixel wide, tallest frame, all classes
      program_regs(0, 32, 1, 8192, 7);
      offer(make_anchor(20, 256, 256, 64, 64, 1, 2, 3, 4, 5, 6, 7));
      offer(make_anchor(21, 256, 256, 64, 64, 0, 0, 0, 0, 0, 0, 0));
      offer(make_anchor(22, 100, 400, 64, 64, 1, 2, 3, 4, 5, 900, 900));
      offer_random(90);
      settle();

      // full threshold, largest model, widest frame, 1-pixel tall, one class
      program_regs(65535, 4096, 8192, 1, 1);
      for (int i = 0; i < 66; i++) begin
         a = rand_anchor();
         if (i % 3 == 0) a.score[0] = '1;
         offer(a);
      end
      settle();

      // degenerate: zero model size, zero class count, zero width, oversized height
      program_regs(1000, 0, 0, 16383, 0);
      offer_random(80);
      settle();

      // long stretch without idling on either side, with a sender pause midway
      program_regs(20000, 320, 1920, 1080, 5);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      offer_random(75);
      drain();
      offer_random(75);
      settle();
      sender_idle_pct   = 17;
      receiver_idle_pct = 17;

      // random settings, alternately within range and raw 16-bit writes
      for (int p = 0; p < 4; p++) begin
         if (p % 2 == 0)
            program_regs($urandom_range(50000), $urandom_range(32, 4096),
                         $urandom_range(1, 8192), $urandom_range(1, 8192),
                         $urandom_range(1, dad_pkg::MAX_CLASSES));
         else
            program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
         offer_random(80);
         settle();
      end

      if (expected_detections.size() != 0) begin
         $display("%0t: %0d expected detections never arrived",
                  $time, expected_detections.size());
         errors += expected_detections.size();
      end
      $display("Decoded %0d anchors over %0d register settings plus defaults,",
               accepted_count, settings_count);
      $display("checked %0d detections, %0d errors.", detections_checked, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
